// ----- hw/rtl/ovn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ovn2d_pkg: shared constants and helpers for the octave value noise block
// Lattice hash constants, the cosine weight table, the blend function and
// the fixed-point widths of the pipeline.
// ----------------------------------------------------------------------------
package ovn2d_pkg;

   localparam int OCTAVES         = 4;
   localparam int WAVELENGTH_LOG2 = 7;
   localparam int COORD_WIDTH     = 16;
   localparam int FRAC_BITS       = 7;

   localparam logic [31:0] HASH_MUL_A = 32'd15731;
   localparam logic [31:0] HASH_ADD_B = 32'd789221;
   localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
   localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
   localparam int          HASH_SHIFT = 13;

   // Smoothed lattice values carry 16 times a 32-bit signed value.
   localparam int SMW   = 36;
   localparam int ACCW  = SMW + OCTAVES;
   localparam int MAGW  = ACCW - 12;

   // Division by 2^OCTAVES - 1 through a scaled reciprocal.
   localparam int          DIV_SHIFT = 27 + 2 * OCTAVES;
   localparam longint      DEN_LO    = (longint'(1) << OCTAVES) - 1;
   localparam longint      DIV_MUL   = ((longint'(1) << DIV_SHIFT) + DEN_LO - 1) / DEN_LO;
   localparam int          MULW      = DIV_SHIFT - OCTAVES + 2;

   localparam logic [15:0] COS_HALF [0:64] = '{
      16'd0, 16'd10, 16'd39, 16'd89, 16'd158, 16'd246, 16'd355, 16'd482, 16'd630,
      16'd796, 16'd982, 16'd1187, 16'd1411, 16'd1654, 16'd1915, 16'd2196, 16'd2494,
      16'd2811, 16'd3146, 16'd3499, 16'd3869, 16'd4257, 16'd4662, 16'd5084, 16'd5522,
      16'd5977, 16'd6448, 16'd6935, 16'd7438, 16'd7956, 16'd8489, 16'd9036, 16'd9598,
      16'd10173, 16'd10762, 16'd11365, 16'd11980, 16'd12608, 16'd13248, 16'd13900,
      16'd14563, 16'd15237, 16'd15922, 16'd16617, 16'd17321, 16'd18035, 16'd18758,
      16'd19489, 16'd20228, 16'd20975, 16'd21729, 16'd22489, 16'd23256, 16'd24028,
      16'd24806, 16'd25588, 16'd26375, 16'd27166, 16'd27960, 16'd28757, 16'd29556,
      16'd30357, 16'd31160, 16'd31964, 16'd32768
   };

   // The upper half of the cosine curve mirrors the lower half.
   function automatic logic [15:0] weight_of(input logic [FRAC_BITS-1:0] k);
      logic [15:0] w;
      logic [7:0]  m;
      begin
         m = 8'd128 - {1'b0, k};
         if (k <= 7'd64) begin
            w = COS_HALF[k];
         end else begin
            w = 16'(17'd65536 - {1'b0, COS_HALF[m[6:0]]});
         end
         return w;
      end
   endfunction

   // Weighted blend of two points; the arithmetic shift rounds toward minus infinity.
   function automatic logic signed [SMW-1:0] blend(input logic signed [SMW-1:0] p1,
                                                  input logic signed [SMW-1:0] p2,
                                                  input logic [15:0] w);
      logic signed [63:0] s;
      logic [16:0]        wc;
      begin
         wc = 17'd65536 - {1'b0, w};
         s  = 64'(p1) * 64'($signed({1'b0, wc})) + 64'(p2) * 64'($signed({2'b0, w}));
         return SMW'(s >>> 16);
      end
   endfunction

endpackage

// ----- hw/rtl/octave_value_noise_2d.sv -----
// ----------------------------------------------------------------------------
// octave_value_noise_2d: fractal value noise, one pixel per clock
// Hashes the lattice around the pixel for every octave, smooths it, blends
// the cell corners with a cosine weight and sums the octaves.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  request   start, busy, req_coord_x, req_coord_y     in (busy out)
//  response  rsp_valid, rsp_noise_value                out
//  csr       csr_wr_en, csr_wr_data (seed)             in
//
// A beat enters in every cycle; its result reaches the response ports after it
// has passed through the eleven-stage pipeline (hash multiplies, smoothing,
// two blend levels, octave sum and reciprocal divide); busy stays low.
// Reset is synchronous and clears the valid bits and sets the seed to 1.
// The receiver cannot stall, so results stream out as beats come in.
// ----------------------------------------------------------------------------
module octave_value_noise_2d
   import ovn2d_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_coord_x,
   input  logic [COORD_WIDTH-1:0] req_coord_y,
   output logic                   rsp_valid,
   output logic signed [23:0]     rsp_noise_value,
   input  logic                   csr_wr_en,
   input  logic signed [31:0]     csr_wr_data
);

   localparam int NSTAGE = 11;

   logic [NSTAGE-1:0] valid_ff;
   logic [31:0]       seed_ff;

   // Stage 1: cell split and row products of the seed.
   logic [31:0]          cx_in  [OCTAVES];
   logic [31:0]          cy_in  [OCTAVES];
   logic [FRAC_BITS-1:0] fx_in  [OCTAVES];
   logic [FRAC_BITS-1:0] fy_in  [OCTAVES];
   logic [31:0]          cx1_ff [OCTAVES];
   logic [31:0]          ys1_ff [OCTAVES][4];
   logic [FRAC_BITS-1:0] fx1_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fy1_ff [OCTAVES];

   // Stages 2 to 4: lattice hash.
   logic [31:0]          n2_in  [OCTAVES][4][4];
   logic [31:0]          n2_ff  [OCTAVES][4][4];
   logic [31:0]          nn2_ff [OCTAVES][4][4];
   logic [31:0]          n3_ff  [OCTAVES][4][4];
   logic [31:0]          m3_ff  [OCTAVES][4][4];
   logic signed [31:0]   g4_ff  [OCTAVES][4][4];
   logic [FRAC_BITS-1:0] fx2_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fy2_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fx3_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fy3_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fx4_ff [OCTAVES];
   logic [FRAC_BITS-1:0] fy4_ff [OCTAVES];

   // Stages 5 to 7: smoothing and cosine blends.
   logic signed [SMW-1:0] sm5_in [OCTAVES][4];
   logic signed [SMW-1:0] sm5_ff [OCTAVES][4];
   logic [15:0]           wx5_ff [OCTAVES];
   logic [15:0]           wy5_ff [OCTAVES];
   logic signed [SMW-1:0] a6_ff  [OCTAVES];
   logic signed [SMW-1:0] b6_ff  [OCTAVES];
   logic [15:0]           wy6_ff [OCTAVES];
   logic signed [SMW-1:0] o7_ff  [OCTAVES];

   // Stages 8 to 11: octave sum and normalization.
   logic signed [ACCW-1:0]  acc8_in;
   logic signed [ACCW-1:0]  acc8_ff;
   logic [ACCW-1:0]         abs9;
   logic                    neg9_ff;
   logic [MAGW-1:0]         mag9_ff;
   logic                    neg10_ff;
   logic [MAGW+MULW-1:0]    prod10_ff;
   logic [23:0]             q11;
   logic signed [23:0]      out_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         seed_ff  <= 32'd1;
      end else begin
         valid_ff <= {valid_ff[NSTAGE-2:0], start};
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   genvar gi, gr, gc;
   generate
      for (gi = 0; gi < OCTAVES; gi++) begin : g_split
         localparam int SH = WAVELENGTH_LOG2 - gi;
         logic [31:0]             cxw, cyw;
         logic [31+FRAC_BITS:0]   tx, ty;
         assign cxw = 32'(req_coord_x);
         assign cyw = 32'(req_coord_y);
         if (SH > 0) begin : g_coarse
            assign tx       = {cxw, {FRAC_BITS{1'b0}}} >> SH;
            assign ty       = {cyw, {FRAC_BITS{1'b0}}} >> SH;
            assign cx_in[gi] = cxw >> SH;
            assign cy_in[gi] = cyw >> SH;
            assign fx_in[gi] = tx[FRAC_BITS-1:0];
            assign fy_in[gi] = ty[FRAC_BITS-1:0];
         end else begin : g_fine
            assign tx       = '0;
            assign ty       = '0;
            assign cx_in[gi] = cxw << (-SH);
            assign cy_in[gi] = cyw << (-SH);
            assign fx_in[gi] = tx[FRAC_BITS-1:0] | ty[FRAC_BITS-1:0];
            assign fy_in[gi] = '0;
         end

         for (gr = 0; gr < 4; gr++) begin : g_row
            for (gc = 0; gc < 4; gc++) begin : g_col
               logic [31:0] nb;
               assign nb = cx1_ff[gi] + 32'(gc) - 32'd1 + ys1_ff[gi][gr];
               assign n2_in[gi][gr][gc] = nb ^ (nb << HASH_SHIFT);
            end
         end

         for (gr = 1; gr < 3; gr++) begin : g_srow
            for (gc = 1; gc < 3; gc++) begin : g_scol
               assign sm5_in[gi][(gr-1)*2 + (gc-1)] =
                  SMW'(g4_ff[gi][gr-1][gc-1]) + SMW'(g4_ff[gi][gr-1][gc+1])
                + SMW'(g4_ff[gi][gr+1][gc-1]) + SMW'(g4_ff[gi][gr+1][gc+1])
                + ((SMW'(g4_ff[gi][gr][gc-1]) + SMW'(g4_ff[gi][gr][gc+1])
                  + SMW'(g4_ff[gi][gr-1][gc]) + SMW'(g4_ff[gi][gr+1][gc])) <<< 1)
                + (SMW'(g4_ff[gi][gr][gc]) <<< 2);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int i = 0; i < OCTAVES; i++) begin
         cx1_ff[i] <= cx_in[i];
         fx1_ff[i] <= fx_in[i];
         fy1_ff[i] <= fy_in[i];
         fx2_ff[i] <= fx1_ff[i];
         fy2_ff[i] <= fy1_ff[i];
         fx3_ff[i] <= fx2_ff[i];
         fy3_ff[i] <= fy2_ff[i];
         fx4_ff[i] <= fx3_ff[i];
         fy4_ff[i] <= fy3_ff[i];
         for (int r = 0; r < 4; r++) begin
            ys1_ff[i][r] <= 32'((cy_in[i] + 32'(r) - 32'd1) * seed_ff);
            for (int c = 0; c < 4; c++) begin
               n2_ff[i][r][c]  <= n2_in[i][r][c];
               nn2_ff[i][r][c] <= 32'(n2_in[i][r][c] * n2_in[i][r][c]);
               n3_ff[i][r][c]  <= n2_ff[i][r][c];
               m3_ff[i][r][c]  <= 32'(nn2_ff[i][r][c] * HASH_MUL_A) + HASH_ADD_B;
               g4_ff[i][r][c]  <= $signed(32'h40000000 -
                  ((32'(n3_ff[i][r][c] * m3_ff[i][r][c]) + HASH_ADD_C) & HASH_MASK));
            end
         end
         for (int k = 0; k < 4; k++) begin
            sm5_ff[i][k] <= sm5_in[i][k];
         end
         wx5_ff[i] <= weight_of(fx4_ff[i]);
         wy5_ff[i] <= weight_of(fy4_ff[i]);
         a6_ff[i]  <= blend(sm5_ff[i][0], sm5_ff[i][1], wx5_ff[i]);
         b6_ff[i]  <= blend(sm5_ff[i][2], sm5_ff[i][3], wx5_ff[i]);
         wy6_ff[i] <= wy5_ff[i];
         o7_ff[i]  <= blend(a6_ff[i], b6_ff[i], wy6_ff[i]);
      end
   end

   // Coarser octaves weigh more: octave i is scaled by 2^(OCTAVES-1-i).
   always_comb begin
      acc8_in = '0;
      for (int i = 0; i < OCTAVES; i++) begin
         acc8_in = acc8_in + (ACCW'(o7_ff[i]) <<< (OCTAVES - 1 - i));
      end
   end

   assign abs9 = acc8_ff[ACCW-1] ? ACCW'(-acc8_ff) : ACCW'(acc8_ff);
   assign q11  = 24'(prod10_ff >> DIV_SHIFT);

   // Division truncates toward zero, so the magnitude is divided and the sign put back.
   always_ff @(posedge clock) begin
      acc8_ff   <= acc8_in;
      neg9_ff   <= acc8_ff[ACCW-1];
      mag9_ff   <= abs9[ACCW-1:12];
      neg10_ff  <= neg9_ff;
      prod10_ff <= (MAGW+MULW)'(mag9_ff) * (MAGW+MULW)'(DIV_MUL[MULW-1:0]);
      out_ff    <= neg10_ff ? $signed(-q11) : $signed(q11);
   end

   assign rsp_valid       = valid_ff[NSTAGE-1];
   assign rsp_noise_value = out_ff;

endmodule

// ----- verif/ovn2d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn2d_checker: noise value scoreboard for octave_value_noise_2d
// Watches accepted coordinate beats, computes the expected noise value with
// its own fixed-point model of the octave sum, and compares every response
// beat against the oldest pending value.
// ----------------------------------------------------------------------------
module ovn2d_checker
   import ovn2d_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_coord_x,
   input  logic [COORD_WIDTH-1:0] req_coord_y,
   input  logic                   rsp_valid,
   input  logic signed [23:0]     rsp_noise_value,
   input  logic                   csr_wr_en,
   input  logic signed [31:0]     csr_wr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int LOG2_WL = WAVELENGTH_LOG2;

   logic [15:0]       cos_tab [0:64];
   logic [31:0]       seed_q;
   logic signed [23:0] noise_q [$];

   initial begin
      cos_tab = '{0, 10, 39, 89, 158, 246, 355, 482, 630, 796,
                  982, 1187, 1411, 1654, 1915, 2196, 2494, 2811, 3146, 3499,
                  3869, 4257, 4662, 5084, 5522, 5977, 6448, 6935, 7438, 7956,
                  8489, 9036, 9598, 10173, 10762, 11365, 11980, 12608, 13248, 13900,
                  14563, 15237, 15922, 16617, 17321, 18035, 18758, 19489, 20228,
                  20975, 21729, 22489, 23256, 24028, 24806, 25588, 26375, 27166,
                  27960, 28757, 29556, 30357, 31160, 31964, 32768};
   end

   function automatic longint cos_weight(input logic [6:0] k);
      if (k <= 7'd64) return longint'(cos_tab[k]);
      return 65536 - longint'(cos_tab[8'd128 - k]);
   endfunction

   function automatic longint hash_value(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] n;
      logic [31:0] t;
      n = x + y * seed_q;
      n = (n << 13) ^ n;
      t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return longint'(32'h40000000) - longint'(t);
   endfunction

   // Arithmetic shift of a signed longint floors, matching the blend rule.
   function automatic longint mix(input longint p1, input longint p2, input longint w);
      return (p1 * (65536 - w) + p2 * w) >>> 16;
   endfunction

   function automatic void split_coord(input logic [31:0] c, input int oct,
                                       output logic [31:0] lat_pos, output logic [6:0] fr);
      int sh;
      logic [31:0] f;
      sh = LOG2_WL - oct;
      if (sh > 0) begin
         lat_pos = c >> sh;
         f = c & ((32'd1 << sh) - 1);
         if (sh >= 7) fr = 7'(f >> (sh - 7));
         else fr = 7'(f << (7 - sh));
      end else begin
         lat_pos = c << (-sh);
         fr = '0;
      end
   endfunction

   function automatic logic signed [23:0] noise_of(input logic [15:0] px,
                                                   input logic [15:0] py);
      longint acc, g [4][4], s [2][2], a, b, wx, wy, q;
      logic [31:0] cx, cy;
      logic [6:0] fx, fy;
      acc = 0;
      for (int i = 0; i < OCTAVES; i++) begin
         split_coord({16'd0, px}, i, cx, fx);
         split_coord({16'd0, py}, i, cy, fy);
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               g[r][c] = hash_value(cx + c - 1, cy + r - 1);
         for (int r = 1; r < 3; r++)
            for (int c = 1; c < 3; c++)
               s[r-1][c-1] = g[r-1][c-1] + g[r-1][c+1] + g[r+1][c-1] + g[r+1][c+1]
                           + 2 * (g[r][c-1] + g[r][c+1] + g[r-1][c] + g[r+1][c])
                           + 4 * g[r][c];
         wx = cos_weight(fx);
         wy = cos_weight(fy);
         a = mix(s[0][0], s[0][1], wx);
         b = mix(s[1][0], s[1][1], wx);
         acc += mix(a, b, wy) * (longint'(1) << (OCTAVES - 1 - i));
      end
      q = acc / (((longint'(1) << OCTAVES) - 1) * 4096);
      return 24'(q);
   endfunction

   always @(posedge clock) begin
      logic signed [23:0] want;
      if (reset) begin
         seed_q     <= 32'd1;
         fail_count <= 0;
         pending    <= 0;
         noise_q.delete();
      end else begin
         if (csr_wr_en) seed_q <= csr_wr_data;
         if (rsp_valid) begin
            if (noise_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected noise beat %0d", rsp_noise_value);
            end else begin
               want = noise_q.pop_front();
               if (want !== rsp_noise_value) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("noise mismatch: expected %0d actual %0d", want,
                              rsp_noise_value);
               end
            end
         end
         if (start && !busy) noise_q.push_back(noise_of(req_coord_x, req_coord_y));
         pending <= noise_q.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for octave_value_noise_2d
// Drives directed and random coordinate beats with random gaps under several
// seeds, and reports the verdict from the noise value checker.
// ----------------------------------------------------------------------------
module tb;
   import ovn2d_pkg::*;

   localparam longint CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [COORD_WIDTH-1:0] req_coord_x;
   logic [COORD_WIDTH-1:0] req_coord_y;
   logic                   rsp_valid;
   logic signed [23:0]     rsp_noise_value;
   logic                   csr_wr_en;
   logic signed [31:0]     csr_wr_data;
   int                     fail_count;
   int                     pending;
   longint                 cycles;

   octave_value_noise_2d u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   ovn2d_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Start stays high between back-to-back beats and drops only for a gap.
   task automatic send_beat(input logic [15:0] x, input logic [15:0] y, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] s);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (15) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      bit burst;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) burst = $urandom_range(0, 2) == 0;
         case ($urandom_range(0, 5))
            0:       send_beat(16'($urandom_range(0, 3)), 16'($urandom), !burst);
            1:       send_beat(16'($urandom), 16'hffff - 16'($urandom_range(0, 3)), !burst);
            default: send_beat(16'($urandom), 16'($urandom), !burst);
         endcase
      end
   endtask

   initial begin
      logic [15:0] edges [6];
      edges = '{16'h0000, 16'h0001, 16'h007f, 16'h0080, 16'h8000, 16'hffff};
      reset       <= 1'b1;
      start       <= 1'b0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Corner coordinates exercise lattice wrap at x-1 and fraction extremes.
      foreach (edges[i]) send_beat(edges[i], edges[5 - i], 1'b1);
      send_beat(16'h0040, 16'h00c0, 1'b0);
      send_beat(16'h5555, 16'haaaa, 1'b0);
      random_phase(150);
      write_seed(32'h8000_0000);
      foreach (edges[i]) send_beat(edges[i], edges[i], 1'b1);
      random_phase(150);
      write_seed(32'h7fff_ffff);
      send_beat(16'h0000, 16'hffff, 1'b1);
      random_phase(150);
      write_seed(32'h0000_0000);
      random_phase(60);
      write_seed(32'hffff_ffff);
      random_phase(60);
      write_seed($urandom);
      random_phase(60);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (15) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
